FILE: src/bbfsr_pkg.sv
// Shared types and constants of the fixed-size byte repacketizer.
package bbfsr_pkg;

  // Field widths of the configuration registers
  localparam int unsigned CaptureW  = 17;
  localparam int unsigned OutSizeW  = 7;
  localparam int unsigned CountW    = 16;
  localparam int unsigned DropW     = 32;

  // Configuration port geometry
  localparam int unsigned AddrW     = 4;
  localparam int unsigned DataW     = 32;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_ENABLE      = 2'd0,
    REG_MAX_CAPTURE = 2'd1,
    REG_OUT_SIZE    = 2'd2,
    REG_DROPPED     = 2'd3
  } reg_idx_e;

  // Reset values of the configuration registers
  localparam logic                ENABLE_RST      = 1'b1;
  localparam logic [CaptureW-1:0] MAX_CAPTURE_RST = 17'd24;
  localparam logic [OutSizeW-1:0] OUT_SIZE_RST    = 7'd0;

  // Saturation limit of the per-packet byte count
  localparam logic [CountW-1:0]   COUNT_MAX       = 16'hFFFF;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic                       enable;
    logic signed [CaptureW-1:0] max_capture;
    logic [OutSizeW-1:0]        out_size;
  } cfg_t;

  // Control states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

endpackage

FILE: src/bbfsr_ring.sv
// Byte ring storage: one write port, one registered read port.
module bbfsr_ring #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/bbfsr_regs.sv
// APB configuration registers and drop counter readback.
module bbfsr_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bbfsr_pkg::AddrW-1:0]    paddr,
  input  logic [bbfsr_pkg::DataW-1:0]    pwdata,
  output logic [bbfsr_pkg::DataW-1:0]    prdata,
  output logic                           pready,
  input  logic [bbfsr_pkg::DropW-1:0]    dropped_i,
  output bbfsr_pkg::cfg_t                cfg_o
);

  bbfsr_pkg::cfg_t      cfg_q, cfg_d;
  bbfsr_pkg::reg_idx_e  idx;
  logic                 wr_req;

  assign pready = 1'b1;
  assign idx    = bbfsr_pkg::reg_idx_e'(paddr[bbfsr_pkg::AddrW-1:2]);
  assign wr_req = psel & penable & pwrite & pready;

  // register writes
  always_comb begin
    cfg_d = cfg_q;
    if (wr_req) begin
      unique case (idx)
        bbfsr_pkg::REG_ENABLE:      cfg_d.enable      = pwdata[0];
        bbfsr_pkg::REG_MAX_CAPTURE: cfg_d.max_capture = pwdata[bbfsr_pkg::CaptureW-1:0];
        bbfsr_pkg::REG_OUT_SIZE:    cfg_d.out_size    = pwdata[bbfsr_pkg::OutSizeW-1:0];
        bbfsr_pkg::REG_DROPPED:     cfg_d             = cfg_q;
        default:                    cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable      <= bbfsr_pkg::ENABLE_RST;
      cfg_q.max_capture <= bbfsr_pkg::MAX_CAPTURE_RST;
      cfg_q.out_size    <= bbfsr_pkg::OUT_SIZE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // readback
  always_comb begin
    prdata = '0;
    unique case (idx)
      bbfsr_pkg::REG_ENABLE:      prdata[0] = cfg_q.enable;
      bbfsr_pkg::REG_MAX_CAPTURE: prdata    = bbfsr_pkg::DataW'(cfg_q.max_capture);
      bbfsr_pkg::REG_OUT_SIZE:    prdata    = bbfsr_pkg::DataW'(cfg_q.out_size);
      bbfsr_pkg::REG_DROPPED:     prdata    = dropped_i;
      default:                    prdata    = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/byte_buffer_fixed_size_repacketizer_unit.sv
// Top level of the fixed-size byte repacketizer: control, ring pointers, output queue.
//
// Packet bytes (tuser = 0) are written into a ring of BUFFER_DEPTH bytes at one per cycle
// while no packet is being emitted; only the first max_capture bytes of each packet are
// kept (all if max_capture is negative), and kept bytes that find the ring full are dropped
// and counted (read the count at byte address 12). A tick (tuser = 1) that follows at least
// one completed packet emits, if out_size is not zero, a packet of exactly
// min(out_size, MAX_OUT_SIZE) bytes: the oldest buffered bytes, then zero padding flagged on
// tuser. Emission reads the ring through its single registered read port at one byte per
// cycle while the output queue has room, so a tick holds the input until all bytes of its
// packet have been issued; a two-entry output queue keeps the read port streaming under
// backpressure. Ring contents are not cleared at reset; only written entries are ever read.
module byte_buffer_fixed_size_repacketizer_unit #(
  parameter int unsigned BUFFER_DEPTH = 4096,
  parameter int unsigned MAX_OUT_SIZE = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] data_byte
  input  logic                        s_axis_tlast,
  input  logic [0:0]                  s_axis_tuser,  // [0] operation
  // output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // [7:0] out_byte
  output logic                        m_axis_tlast,
  output logic [0:0]                  m_axis_tuser,  // [0] is_padding
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bbfsr_pkg::AddrW-1:0] paddr,
  input  logic [bbfsr_pkg::DataW-1:0] pwdata,
  output logic [bbfsr_pkg::DataW-1:0] prdata,
  output logic                        pready
);

  localparam int unsigned PtrW = $clog2(BUFFER_DEPTH);
  localparam int unsigned FillW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned SumW = PtrW + 1;
  localparam int unsigned SzW = bbfsr_pkg::OutSizeW;
  localparam logic [SzW-1:0] MaxSize = SzW'(MAX_OUT_SIZE);

  typedef struct packed {
    logic [7:0] data;
    logic       pad;
    logic       last;
  } q_entry_t;

  bbfsr_pkg::cfg_t cfg;

  // control and pointer state
  bbfsr_pkg::state_e               state_q, state_d;
  logic [PtrW-1:0]                 rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0]                fill_q, fill_d;
  logic [bbfsr_pkg::CountW-1:0]    pkt_cnt_q, pkt_cnt_d;
  logic                            arrived_q, arrived_d;
  logic [bbfsr_pkg::DropW-1:0]     dropped_q, dropped_d;
  logic [SzW-1:0]                  size_q, size_d;
  logic [SzW-1:0]                  take_q, take_d;
  logic [SzW-1:0]                  k_q, k_d;

  // read in flight and output queue
  logic                            infl_q, infl_d;
  logic                            infl_pad_q, infl_pad_d;
  logic                            infl_last_q, infl_last_d;
  q_entry_t                        q_mem_q [2];
  logic                            q_wr_q, q_rd_q;
  logic [1:0]                      q_cnt_q, q_cnt_d;

  // datapath signals
  logic                            in_req, byte_req, tick_req, keep;
  logic [SumW-1:0]                 wr_sum;
  logic [PtrW-1:0]                 wr_addr;
  logic                            ring_we, ring_re, issue, pop, push;
  logic [7:0]                      ring_rdata;
  logic [SzW-1:0]                  size_sat;
  logic [2:0]                      slots;

  bbfsr_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .dropped_i (dropped_q),
    .cfg_o     (cfg)
  );

  bbfsr_ring #(
    .Depth (BUFFER_DEPTH),
    .AddrW (PtrW)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (ring_we),
    .wr_addr_i (wr_addr),
    .wr_data_i (s_axis_tdata),
    .rd_en_i   (ring_re),
    .rd_addr_i (rd_ptr_q),
    .rd_data_o (ring_rdata)
  );

  assign s_axis_tready = (state_q == bbfsr_pkg::ST_IDLE);
  assign in_req   = s_axis_tvalid & s_axis_tready & cfg.enable;
  assign byte_req = in_req & ~s_axis_tuser[0];
  assign tick_req = in_req & s_axis_tuser[0];

  // capture limit and ring write address
  assign keep    = cfg.max_capture[bbfsr_pkg::CaptureW-1] |
                   (pkt_cnt_q < cfg.max_capture[bbfsr_pkg::CountW-1:0]);
  assign wr_sum  = SumW'(rd_ptr_q) + SumW'(fill_q);
  assign wr_addr = (wr_sum >= SumW'(BUFFER_DEPTH)) ?
                   PtrW'(wr_sum - SumW'(BUFFER_DEPTH)) : PtrW'(wr_sum);
  assign ring_we = byte_req & keep & (fill_q < FillW'(BUFFER_DEPTH));

  assign size_sat = (cfg.out_size > MaxSize) ? MaxSize : cfg.out_size;

  // a byte may be issued when the queue has room counting the one in flight
  assign pop     = m_axis_tvalid & m_axis_tready;
  assign push    = infl_q;
  assign slots   = 3'(q_cnt_q) + 3'(infl_q) - 3'(pop);
  assign issue   = (state_q == bbfsr_pkg::ST_EMIT) && (slots < 3'd2);
  assign ring_re = issue && (k_q < take_q);

  // next state
  always_comb begin
    state_d     = state_q;
    rd_ptr_d    = rd_ptr_q;
    fill_d      = fill_q;
    pkt_cnt_d   = pkt_cnt_q;
    arrived_d   = arrived_q;
    dropped_d   = dropped_q;
    size_d      = size_q;
    take_d      = take_q;
    k_d         = k_q;
    infl_d      = issue;
    infl_pad_d  = ~ring_re;
    infl_last_d = (k_q == size_q - SzW'(1));

    unique case (state_q)
      bbfsr_pkg::ST_IDLE: begin
        if (byte_req) begin
          if (ring_we) begin
            fill_d = fill_q + FillW'(1);
          end else if (keep) begin
            dropped_d = dropped_q + bbfsr_pkg::DropW'(1);
          end
          if (pkt_cnt_q < bbfsr_pkg::COUNT_MAX) begin
            pkt_cnt_d = pkt_cnt_q + bbfsr_pkg::CountW'(1);
          end
          if (s_axis_tlast) begin
            arrived_d = 1'b1;
            pkt_cnt_d = '0;
          end
        end else if (tick_req) begin
          arrived_d = 1'b0;
          if ((cfg.out_size != '0) && arrived_q) begin
            size_d  = size_sat;
            take_d  = (fill_q < FillW'(size_sat)) ? SzW'(fill_q) : size_sat;
            k_d     = '0;
            state_d = bbfsr_pkg::ST_EMIT;
          end
        end
      end
      bbfsr_pkg::ST_EMIT: begin
        if (issue) begin
          k_d = k_q + SzW'(1);
          if (ring_re) begin
            fill_d   = fill_q - FillW'(1);
            rd_ptr_d = (rd_ptr_q == PtrW'(BUFFER_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
          end
          if (k_q == size_q - SzW'(1)) begin
            state_d = bbfsr_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = bbfsr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bbfsr_pkg::ST_IDLE;
      rd_ptr_q  <= '0;
      fill_q    <= '0;
      pkt_cnt_q <= '0;
      arrived_q <= 1'b0;
      dropped_q <= '0;
      size_q    <= '0;
      take_q    <= '0;
      k_q       <= '0;
      infl_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_ptr_q  <= rd_ptr_d;
      fill_q    <= fill_d;
      pkt_cnt_q <= pkt_cnt_d;
      arrived_q <= arrived_d;
      dropped_q <= dropped_d;
      size_q    <= size_d;
      take_q    <= take_d;
      k_q       <= k_d;
      infl_q    <= infl_d;
    end
  end

  // tags of the byte in flight through the read port
  always_ff @(posedge clk_i) begin
    infl_pad_q  <= infl_pad_d;
    infl_last_q <= infl_last_d;
  end

  // output queue, two entries
  assign q_cnt_d = q_cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= 1'b0;
      q_rd_q  <= 1'b0;
      q_cnt_q <= '0;
    end else begin
      q_cnt_q <= q_cnt_d;
      if (push) begin
        q_wr_q <= ~q_wr_q;
      end
      if (pop) begin
        q_rd_q <= ~q_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[q_wr_q].data <= infl_pad_q ? 8'd0 : ring_rdata;
      q_mem_q[q_wr_q].pad  <= infl_pad_q;
      q_mem_q[q_wr_q].last <= infl_last_q;
    end
  end

  assign m_axis_tvalid   = (q_cnt_q != 2'd0);
  assign m_axis_tdata    = q_mem_q[q_rd_q].data;
  assign m_axis_tuser[0] = q_mem_q[q_rd_q].pad;
  assign m_axis_tlast    = q_mem_q[q_rd_q].last;

`ifndef SYNTHESIS
  // queue plus in-flight read never exceeds its two entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (3'(q_cnt_q) + 3'(infl_q)) <= 3'd2)
    else $error("output queue overrun");

  // fill level stays within the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(BUFFER_DEPTH))
    else $error("fill level beyond ring depth");

  // no ring write while the read port is streaming a packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_re |-> !ring_we)
    else $error("ring write during emission");

  // an issued byte, ring read or padding, shows up in the queue next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> push)
    else $error("issued byte lost before queue");

  // emitted data bytes never outnumber the packet size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bbfsr_pkg::ST_EMIT) |-> (take_q <= size_q) && (k_q < size_q))
    else $error("emission counters out of range");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the fixed-size byte repacketizer.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned RING_DEPTH    = 4096;
  localparam int unsigned OUT_MAX       = 64;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned QUIET_LIMIT   = 3000;
  localparam logic        OP_BYTE       = 1'b0;
  localparam logic        OP_TICK       = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       pend;
  } link_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       pad;
    logic       last;
  } shaped_byte_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [7:0]                       s_axis_tdata = '0;   // [7:0] data_byte
  logic                             s_axis_tlast = 1'b0;
  logic [0:0]                       s_axis_tuser = '0;   // [0] operation
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [7:0]                       m_axis_tdata;        // [7:0] out_byte
  logic                             m_axis_tlast;
  logic [0:0]                       m_axis_tuser;        // [0] is_padding
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [bbfsr_pkg::AddrW-1:0]      paddr = '0;
  logic [bbfsr_pkg::DataW-1:0]      pwdata = '0;
  logic [bbfsr_pkg::DataW-1:0]      prdata;
  logic                             pready;

  byte_buffer_fixed_size_repacketizer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Stimulus and scoreboard bookkeeping
  link_item_t   pending_items[$];
  shaped_byte_t expected_bytes[$];
  int unsigned  items_queued = 0;
  int unsigned  items_taken = 0;
  int unsigned  mismatch_cnt = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  tx_idle_pct = 18;
  int unsigned  rx_idle_pct = 18;
  int unsigned  rx_hold_left = 0;
  bit           in_taken = 1'b0;

  // Shadow state of the shaper
  logic [7:0]   ring_mem [RING_DEPTH];
  int unsigned  ring_rd = 0;
  int unsigned  ring_fill = 0;
  logic [15:0]  pkt_len = '0;
  bit           pkt_arrived = 1'b0;
  logic [31:0]  drop_total = '0;
  bit           cfg_enable = 1'b1;
  int           cfg_capture = 24;
  int unsigned  cfg_out_size = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Shaper prediction for one accepted request
  task automatic repacketize_item(input link_item_t it);
    int unsigned  size;
    int unsigned  take;
    bit           keep;
    shaped_byte_t r;
    if (!cfg_enable) return;
    if (it.op == OP_BYTE) begin
      keep = (cfg_capture < 0) || (int'(pkt_len) < cfg_capture);
      if (keep) begin
        if (ring_fill < RING_DEPTH) begin
          ring_mem[(ring_rd + ring_fill) % RING_DEPTH] = it.data;
          ring_fill++;
        end else begin
          drop_total = drop_total + 32'd1;
        end
      end
      if (pkt_len != bbfsr_pkg::COUNT_MAX) pkt_len = pkt_len + 16'd1;
      if (it.pend) begin
        pkt_arrived = 1'b1;
        pkt_len = '0;
      end
    end else begin
      keep = (cfg_out_size != 0) && pkt_arrived;
      pkt_arrived = 1'b0;
      if (!keep) return;
      size = (cfg_out_size > OUT_MAX) ? OUT_MAX : cfg_out_size;
      take = (ring_fill < size) ? ring_fill : size;
      for (int unsigned k = 0; k < size; k++) begin
        if (k < take) begin
          r.value = ring_mem[ring_rd];
          r.pad   = 1'b0;
          ring_rd = (ring_rd + 1) % RING_DEPTH;
        end else begin
          r.value = 8'h00;
          r.pad   = 1'b1;
        end
        r.last = (k + 1 == size);
        expected_bytes.push_back(r);
      end
      ring_fill -= take;
    end
  endtask

  // Input driver: next request or a random gap
  always @(negedge clk_i) begin : feed
    link_item_t nxt;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.op;
        s_axis_tdata  <= nxt.data;
        s_axis_tlast  <= nxt.pend;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output ready: long hold-off when requested, else random stalls
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: check results first, then predict the accepted request
  always @(posedge clk_i) begin : watch
    shaped_byte_t want;
    link_item_t   got_item;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte: expected none, got value %02h pad %0b last %0b",
                   $time, m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
          mismatch_cnt++;
        end else begin
          want = expected_bytes.pop_front();
          if (m_axis_tdata !== want.value || m_axis_tuser[0] !== want.pad ||
              m_axis_tlast !== want.last) begin
            $display("%0t: expected value %02h pad %0b last %0b, got value %02h pad %0b last %0b",
                     $time, want.value, want.pad, want.last,
                     m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
            mismatch_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        got_item = {s_axis_tuser[0], s_axis_tdata, s_axis_tlast};
        repacketize_item(got_item);
        in_taken = 1'b1;
        items_taken++;
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic push_item(input logic op, input logic [7:0] data, input logic pend);
    pending_items.push_back({op, data, pend});
    items_queued++;
  endtask

  task automatic push_packet(input int unsigned len);
    for (int unsigned i = 1; i <= len; i++) push_item(OP_BYTE, 8'($urandom), i == len);
  endtask

  // Wait until every request is taken and every result seen, then let the pipe drain
  task automatic settle();
    do @(posedge clk_i);
    while (items_taken != items_queued || expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input bit wr, input bbfsr_pkg::reg_idx_e idx,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(input bbfsr_pkg::reg_idx_e idx, input int value);
    logic [31:0] wdata;
    logic [31:0] unused;
    wdata = 32'(value);
    apb_xfer(1'b1, idx, wdata, unused);
    case (idx)
      bbfsr_pkg::REG_ENABLE:      cfg_enable = wdata[0];
      bbfsr_pkg::REG_MAX_CAPTURE: cfg_capture = int'($signed(wdata[16:0]));
      bbfsr_pkg::REG_OUT_SIZE:    cfg_out_size = wdata[6:0];
      default: ;
    endcase
  endtask

  task automatic check_drop_count();
    logic [31:0] got;
    apb_xfer(1'b0, bbfsr_pkg::REG_DROPPED, '0, got);
    if (got !== drop_total) begin
      $display("%0t: dropped count expected %0d, got %0d", $time, drop_total, got);
      mismatch_cnt++;
    end
  endtask

  // Mostly well-formed packets and ticks, with some stray requests
  task automatic random_traffic(input int unsigned n);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 6);
        push_packet(len);
        sent += len;
      end else if (pick < 85) begin
        push_item(OP_TICK, 8'($urandom), 1'($urandom));
        sent++;
      end else begin
        push_item(1'($urandom), 8'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Tick with emission off still clears the arrival flag
    push_item(OP_BYTE, 8'h00, 1'b0);
    push_item(OP_BYTE, 8'hFF, 1'b1);
    push_item(OP_TICK, 8'h00, 1'b0);
    settle();
    write_reg(bbfsr_pkg::REG_OUT_SIZE, 4);
    // no packet since last tick: nothing; then data plus padding
    push_item(OP_TICK, 8'hFF, 1'b1);
    push_item(OP_BYTE, 8'h5A, 1'b1);
    push_item(OP_TICK, 8'h00, 1'b0);
    settle();
    // capture limit cuts a longer packet
    write_reg(bbfsr_pkg::REG_MAX_CAPTURE, 2);
    push_packet(5);
    push_item(OP_TICK, 8'h00, 1'b0);
    settle();
    // oversized packet size saturates
    write_reg(bbfsr_pkg::REG_OUT_SIZE, 127);
    push_packet(1);
    push_item(OP_TICK, 8'h00, 1'b0);
    settle();
    write_reg(bbfsr_pkg::REG_OUT_SIZE, 1);
    push_packet(2);
    push_item(OP_TICK, 8'h00, 1'b0);
    settle();
    // disabled: everything ignored
    write_reg(bbfsr_pkg::REG_ENABLE, 0);
    push_packet(3);
    push_item(OP_TICK, 8'h00, 1'b0);
    settle();
    write_reg(bbfsr_pkg::REG_ENABLE, 1);
    push_item(OP_TICK, 8'h00, 1'b0);
    settle();
    write_reg(bbfsr_pkg::REG_MAX_CAPTURE, 0);
    push_packet(3);
    push_item(OP_TICK, 8'h00, 1'b0);
    settle();
    check_drop_count();

    // Random phases over several settings
    write_reg(bbfsr_pkg::REG_MAX_CAPTURE, -1);
    write_reg(bbfsr_pkg::REG_OUT_SIZE, 16);
    random_traffic(30);
    settle();
    // long stretch with no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(bbfsr_pkg::REG_MAX_CAPTURE, 24);
    write_reg(bbfsr_pkg::REG_OUT_SIZE, 8);
    random_traffic(30);
    settle();
    tx_idle_pct = 18;
    rx_idle_pct = 18;
    write_reg(bbfsr_pkg::REG_MAX_CAPTURE, 5);
    write_reg(bbfsr_pkg::REG_OUT_SIZE, 64);
    random_traffic(25);
    settle();
    write_reg(bbfsr_pkg::REG_MAX_CAPTURE, -65536);
    write_reg(bbfsr_pkg::REG_OUT_SIZE, 3);
    random_traffic(20);
    settle();
    write_reg(bbfsr_pkg::REG_MAX_CAPTURE, 1);
    write_reg(bbfsr_pkg::REG_OUT_SIZE, 127);
    random_traffic(20);
    settle();
    write_reg(bbfsr_pkg::REG_ENABLE, 0);
    random_traffic(10);
    settle();
    write_reg(bbfsr_pkg::REG_ENABLE, 1);
    write_reg(bbfsr_pkg::REG_MAX_CAPTURE, 65535);
    write_reg(bbfsr_pkg::REG_OUT_SIZE, 32);
    random_traffic(20);
    settle();

    // Receiver holds off while the sender keeps offering
    write_reg(bbfsr_pkg::REG_MAX_CAPTURE, -1);
    write_reg(bbfsr_pkg::REG_OUT_SIZE, 64);
    @(posedge clk_i);
    rx_hold_left = 400;
    repeat (4) begin
      push_packet($urandom_range(2, 8));
      push_item(OP_TICK, 8'($urandom), 1'($urandom));
    end
    random_traffic(20);
    settle();
    check_drop_count();

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
